FILE: rtl/core/popa_pkg.sv
package popa_pkg;

  localparam int unsigned MaxPages  = 16;
  localparam int unsigned MaxSlots  = 256;
  localparam int unsigned PageW     = $clog2(MaxPages);
  localparam int unsigned SlotW     = $clog2(MaxSlots);
  localparam int unsigned CountW    = SlotW + 1;
  localparam int unsigned PagesW    = PageW + 1;
  localparam int unsigned LinkAddrW = PageW + SlotW;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusNoMem  = 2'd1;
  localparam logic [1:0] StatusReject = 2'd2;

  localparam logic CfgSlots = 1'b0;
  localparam logic CfgLimit = 1'b1;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StDecide,
    StBuild,
    StPopRead,
    StPopWait,
    StPop,
    StPush,
    StSearch,
    StOut
  } state_e;

  typedef struct packed {
    logic load_req;
    logic start_build;
    logic build_step;
    logic pop_commit;
    logic push_commit;
    logic search_start;
    logic search_step;
    logic set_nomem;
    logic set_reject;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic nonfull_valid;
    logic can_claim;
    logic build_done;
    logic nonfull_empty;
    logic pop_fills;
    logic free_bad;
    logic search_done;
  } sts_t;

endpackage

FILE: rtl/core/popa_ram.sv
module popa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/popa_datapath.sv
module popa_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [8:0]                 cfg_data_i,
  input  logic                       action_i,
  input  logic [popa_pkg::PageW-1:0] free_page_i,
  input  logic [popa_pkg::SlotW-1:0] free_slot_i,
  input  popa_pkg::cmd_t             cmd_i,
  output popa_pkg::sts_t             sts_o,
  output logic [1:0]                 status_o,
  output logic [popa_pkg::PageW-1:0] obj_page_o,
  output logic [popa_pkg::SlotW-1:0] obj_slot_o,
  output logic                       took_new_page_o
);
  import popa_pkg::*;

  logic [8:0]         slots_cfg_q;
  logic [4:0]         limit_cfg_q;
  logic [CountW-1:0]  eff_slots;
  logic [PagesW-1:0]  eff_limit;
  logic               act_q;
  logic [PageW-1:0]   fpage_q;
  logic [SlotW-1:0]   fslot_q;
  logic [PagesW-1:0]  pages_q;
  logic [PageW-1:0]   nf_page_q;
  logic               nf_valid_q;
  logic [SlotW-1:0]   heads_q  [MaxPages];
  logic [CountW-1:0]  counts_q [MaxPages];
  logic [CountW-1:0]  bidx_q;
  logic [PagesW-1:0]  sidx_q;
  logic [1:0]         status_q;
  logic [PageW-1:0]   opage_q;
  logic [SlotW-1:0]   oslot_q;
  logic               took_q;
  logic               link_we;
  logic [LinkAddrW-1:0] link_waddr;
  logic [LinkAddrW-1:0] link_raddr;
  logic [SlotW-1:0]   link_wdata;
  logic [SlotW-1:0]   link_rdata;
  logic [PageW-1:0]   wpage;
  logic [CountW-1:0]  nxt;
  logic [PageW-1:0]   scur;

  always_comb begin
    eff_slots = slots_cfg_q[CountW-1:0];
    if (slots_cfg_q == 9'd0) eff_slots = CountW'(1);
    else if (slots_cfg_q > 9'(MaxSlots)) eff_slots = CountW'(MaxSlots);
    eff_limit = (limit_cfg_q > 5'(MaxPages)) ? PagesW'(MaxPages) : PagesW'(limit_cfg_q);
  end

  assign wpage = pages_q[PageW-1:0];
  assign nxt   = bidx_q + CountW'(1);
  assign scur  = PageW'(sidx_q - PagesW'(1));

  always_comb begin
    link_we    = 1'b0;
    link_waddr = {wpage, bidx_q[SlotW-1:0]};
    link_wdata = (nxt < eff_slots) ? nxt[SlotW-1:0] : '0;
    link_raddr = {nf_page_q, heads_q[nf_page_q]};
    if (cmd_i.build_step) begin
      link_we = 1'b1;
    end else if (cmd_i.push_commit) begin
      link_we    = 1'b1;
      link_waddr = {fpage_q, fslot_q};
      link_wdata = heads_q[fpage_q];
    end
  end

  popa_ram #(.Width(SlotW), .Depth(MaxPages * MaxSlots)) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  always_comb begin
    sts_o.is_alloc      = (act_q == ActAlloc);
    sts_o.nonfull_valid = nf_valid_q;
    sts_o.can_claim     = pages_q < eff_limit;
    sts_o.build_done    = nxt >= eff_slots;
    sts_o.nonfull_empty = counts_q[nf_page_q] == '0;
    sts_o.pop_fills     = counts_q[nf_page_q] == CountW'(1);
    sts_o.free_bad      = (PagesW'(fpage_q) >= pages_q) ||
                          (CountW'(fslot_q) >= eff_slots) ||
                          (counts_q[fpage_q] >= eff_slots);
    sts_o.search_done   = (sidx_q == '0) || (counts_q[scur] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_cfg_q <= 9'd64;
      limit_cfg_q <= 5'd16;
      pages_q     <= '0;
      nf_page_q   <= '0;
      nf_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgSlots) slots_cfg_q <= cfg_data_i;
        else limit_cfg_q <= cfg_data_i[4:0];
      end
      if (cmd_i.start_build) begin
        nf_page_q  <= wpage;
        nf_valid_q <= 1'b1;
      end
      if (cmd_i.build_step && sts_o.build_done) begin
        pages_q <= pages_q + PagesW'(1);
      end
      if (cmd_i.push_commit && !nf_valid_q) begin
        nf_page_q  <= fpage_q;
        nf_valid_q <= 1'b1;
      end
      if (cmd_i.search_start) begin
        nf_valid_q <= 1'b0;
        nf_page_q  <= '0;
      end
      if (cmd_i.search_step && sidx_q != '0 && counts_q[scur] != '0) begin
        nf_valid_q <= 1'b1;
        nf_page_q  <= scur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q    <= action_i;
      fpage_q  <= free_page_i;
      fslot_q  <= free_slot_i;
      status_q <= StatusOk;
      opage_q  <= '0;
      oslot_q  <= '0;
      took_q   <= 1'b0;
    end
    if (cmd_i.start_build) begin
      bidx_q <= '0;
      took_q <= 1'b1;
    end
    if (cmd_i.build_step) begin
      bidx_q <= nxt;
      if (sts_o.build_done) begin
        heads_q[wpage]  <= '0;
        counts_q[wpage] <= eff_slots;
      end
    end
    if (cmd_i.pop_commit) begin
      heads_q[nf_page_q]  <= link_rdata;
      counts_q[nf_page_q] <= counts_q[nf_page_q] - CountW'(1);
      opage_q <= nf_page_q;
      oslot_q <= heads_q[nf_page_q];
    end
    if (cmd_i.push_commit) begin
      heads_q[fpage_q]  <= fslot_q;
      counts_q[fpage_q] <= counts_q[fpage_q] + CountW'(1);
    end
    if (cmd_i.search_start) sidx_q <= pages_q;
    if (cmd_i.search_step) sidx_q <= sidx_q - PagesW'(1);
    if (cmd_i.set_nomem) begin
      status_q <= StatusNoMem;
      took_q   <= 1'b0;
    end
    if (cmd_i.set_reject) status_q <= StatusReject;
  end

  assign status_o        = status_q;
  assign obj_page_o      = opage_q;
  assign obj_slot_o      = oslot_q;
  assign took_new_page_o = took_q;
endmodule

FILE: rtl/core/popa_ctrl.sv
module popa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  popa_pkg::sts_t sts_i,
  output popa_pkg::cmd_t cmd_o
);
  import popa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (sts_i.is_alloc) begin
          if (sts_i.nonfull_valid) begin
            state_d = StPopRead;
          end else if (sts_i.can_claim) begin
            cmd_o.start_build = 1'b1;
            state_d = StBuild;
          end else begin
            cmd_o.set_nomem = 1'b1;
            state_d = StOut;
          end
        end else if (sts_i.free_bad) begin
          cmd_o.set_reject = 1'b1;
          state_d = StOut;
        end else begin
          state_d = StPush;
        end
      end
      StBuild: begin
        cmd_o.build_step = 1'b1;
        if (sts_i.build_done) state_d = StPopRead;
      end
      StPopRead: begin
        if (sts_i.nonfull_empty) begin
          cmd_o.set_nomem = 1'b1;
          state_d = StOut;
        end else begin
          state_d = StPopWait;
        end
      end
      StPopWait: state_d = StPop;
      StPop: begin
        cmd_o.pop_commit = 1'b1;
        if (sts_i.pop_fills) begin
          cmd_o.search_start = 1'b1;
          state_d = StSearch;
        end else begin
          state_d = StOut;
        end
      end
      StPush: begin
        cmd_o.push_commit = 1'b1;
        state_d = StOut;
      end
      StSearch: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.search_done) state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

FILE: rtl/core/paged_object_pool_allocator_unit.sv
// Each request occupies the unit from its acceptance cycle until its result is taken.
// A successful free goes decide, push, output; a rejected free or a failed allocation goes
// decide, output; an allocation from a held page goes decide, pop-read, pop-wait, pop,
// output, plus slot-linking build steps on a fresh page and a page search when it fills it.
// One request is in flight at a time; the result register holds until taken.
// Reset clears control state and loads slots_per_page 64 and page_limit 16.
module paged_object_pool_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [8:0]                 cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [popa_pkg::PageW-1:0] free_page_i,
  input  logic [popa_pkg::SlotW-1:0] free_slot_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [popa_pkg::PageW-1:0] obj_page_o,
  output logic [popa_pkg::SlotW-1:0] obj_slot_o,
  output logic                       took_new_page_o
);
  import popa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  popa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  popa_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .free_page_i     (free_page_i),
    .free_slot_i     (free_slot_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .obj_page_o      (obj_page_o),
    .obj_slot_o      (obj_slot_o),
    .took_new_page_o (took_new_page_o)
  );
endmodule

FILE: bench/pool_checker.sv
module pool_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [8:0]                 cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       action_i,
  input  logic [popa_pkg::PageW-1:0] free_page_i,
  input  logic [popa_pkg::SlotW-1:0] free_slot_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [1:0]                 status_i,
  input  logic [popa_pkg::PageW-1:0] obj_page_i,
  input  logic [popa_pkg::SlotW-1:0] obj_slot_i,
  input  logic                       took_new_page_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import popa_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [PageW-1:0] page;
    logic [SlotW-1:0] slot;
    logic             took;
  } outcome_t;

  outcome_t expected_q[$];

  logic [CountW-1:0] link_mem [MaxPages*MaxSlots];
  logic [CountW-1:0] head_mem [MaxPages];
  logic [CountW-1:0] count_mem [MaxPages];
  int unsigned pages_used;
  int unsigned open_page;
  bit open_valid;
  logic [8:0] slots_reg;
  logic [4:0] limit_reg;

  function automatic int unsigned slot_count();
    if (slots_reg == 0) return 1;
    if (slots_reg > MaxSlots) return MaxSlots;
    return slots_reg;
  endfunction

  function automatic void seek_open_page();
    int i;
    open_valid = 0;
    open_page = 0;
    for (i = int'(pages_used) - 1; i >= 0; i--) begin
      if (count_mem[i] > 0) begin
        open_page = unsigned'(i);
        open_valid = 1;
        return;
      end
    end
  endfunction

  function automatic outcome_t serve_request(logic act, int unsigned fpage,
                                             int unsigned fslot);
    outcome_t r;
    int unsigned n, lim, pg, s, i;
    n = slot_count();
    lim = (limit_reg > MaxPages) ? MaxPages : limit_reg;
    r = '0;
    if (act == ActAlloc) begin
      if (!open_valid) begin
        if (pages_used < lim) begin
          pg = pages_used;
          for (i = 0; i < n; i++)
            link_mem[pg*MaxSlots+i] = CountW'((i + 1 < n) ? i + 1 : 0);
          head_mem[pg] = '0;
          count_mem[pg] = CountW'(n);
          pages_used++;
          open_page = pg;
          open_valid = 1;
          r.took = 1;
        end else r.status = StatusNoMem;
      end
      if (r.status == StatusOk) begin
        pg = open_page % MaxPages;
        if (count_mem[pg] == 0) begin
          r.status = StatusNoMem;
          r.took = 0;
        end else begin
          s = head_mem[pg] % MaxSlots;
          head_mem[pg] = link_mem[pg*MaxSlots+s];
          count_mem[pg]--;
          r.page = PageW'(pg);
          r.slot = SlotW'(s);
          if (count_mem[pg] == 0) seek_open_page();
        end
      end
    end else if (fpage >= pages_used || fslot >= n || count_mem[fpage] >= n) begin
      r.status = StatusReject;
    end else begin
      link_mem[fpage*MaxSlots+fslot] = head_mem[fpage];
      head_mem[fpage] = CountW'(fslot);
      count_mem[fpage]++;
      if (!open_valid) begin
        open_page = fpage;
        open_valid = 1;
      end
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    outcome_t e, a;
    if (!rst_ni) begin
      expected_q.delete();
      pages_used = 0;
      open_page = 0;
      open_valid = 0;
      slots_reg = 9'd64;
      limit_reg = 5'd16;
      fail_count_o <= 0;
      for (int i = 0; i < MaxPages; i++) begin
        head_mem[i] = '0;
        count_mem[i] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgSlots) slots_reg = cfg_data_i;
        else limit_reg = cfg_data_i[4:0];
      end
      if (out_valid_i && !out_stall_i) begin
        a = '{status_i, obj_page_i, obj_slot_i, took_new_page_i};
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result %p", a);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== a) begin
            if (fail_count_o < 10) $display("Mismatch: expected %p, got %p", e, a);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(serve_request(action_i, free_page_i, free_slot_i));
    end
  end
endmodule

FILE: bench/testbench.sv
module testbench;
  import popa_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we, cfg_index;
  logic [8:0] cfg_data;
  logic in_valid, in_stall, action;
  logic [PageW-1:0] free_page;
  logic [SlotW-1:0] free_slot;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic [PageW-1:0] obj_page;
  logic [SlotW-1:0] obj_slot;
  logic took_new_page;
  int fail_count, pending, idle_cycles;
  bit timed_out;

  typedef struct {
    int unsigned page;
    int unsigned slot;
  } handle_t;
  handle_t live_objects[$];
  logic action_q[$];

  always #5 clk_i = ~clk_i;

  paged_object_pool_allocator_unit u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .free_page_i(free_page), .free_slot_i(free_slot),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .obj_page_o(obj_page), .obj_slot_o(obj_slot),
    .took_new_page_o(took_new_page)
  );

  pool_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .free_page_i(free_page), .free_slot_i(free_slot),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .obj_page_i(obj_page), .obj_slot_i(obj_slot),
    .took_new_page_i(took_new_page),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Live objects are learnt from the results so that most frees are legal.
  always @(posedge clk_i) begin
    if (out_valid && !out_stall && action_q.size() > 0) begin
      if (rst_ni && action_q[0] == ActAlloc && status == StatusOk)
        live_objects.push_back('{obj_page, obj_slot});
      void'(action_q.pop_front());
    end
    if (in_valid && !in_stall) action_q.push_back(action);
  end

  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if ((($time / 2000) % 3) == 0) out_stall <= 1'b0;
    else out_stall <= (r < 40);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 9'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(logic act, int unsigned pg, int unsigned sl);
    int gap;
    action <= act;
    free_page <= PageW'(pg);
    free_slot <= SlotW'(sl);
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pool();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_mix(int count);
    int k, pick, idx;
    handle_t h;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) send_request(ActAlloc, $urandom, $urandom);
      else if (pick < 88 && live_objects.size() > 0) begin
        idx = $urandom_range(0, live_objects.size() - 1);
        h = live_objects[idx];
        live_objects.delete(idx);
        send_request(ActFree, h.page, h.slot);
      end else send_request(ActFree, $urandom_range(0, 15), $urandom_range(0, 255));
    end
  endtask

  initial begin
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; action = 0; free_page = 0; free_slot = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CfgSlots, 0);
    write_reg(CfgLimit, 2);
    send_request(ActFree, 0, 0);
    repeat (3) send_request(ActAlloc, 0, 0);
    send_request(ActFree, 1, 0);
    send_request(ActFree, 1, 0);
    send_request(ActFree, 0, 1);
    send_request(ActFree, 15, 255);
    send_request(ActAlloc, 15, 255);
    drain_pool();
    write_reg(CfgSlots, 3);
    write_reg(CfgLimit, 0);
    repeat (6) send_request(ActAlloc, 0, 0);
    send_request(ActFree, 1, 2);
    send_request(ActFree, 0, 3);
    drain_pool();
    live_objects.delete();
    write_reg(CfgSlots, 9'h1FF);
    write_reg(CfgLimit, 5'h1F);
    random_mix(60);
    drain_pool();
    write_reg(CfgSlots, 1);
    random_mix(100);
    drain_pool();
    write_reg(CfgSlots, 5);
    write_reg(CfgLimit, 16);
    random_mix(120);
    drain_pool();
    write_reg(CfgSlots, 256);
    random_mix(100);
    drain_pool();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
